// File: hdl/rsi_ema_indicator_defines.svh
// ----------------------------------------------------------------------------
// rsi_ema_indicator_defines.svh
// assertion macros shared by the rsi blocks
// ----------------------------------------------------------------------------
`ifndef RSI_EMA_INDICATOR_DEFINES_SVH
`define RSI_EMA_INDICATOR_DEFINES_SVH

// implication checked in the same cycle, off while in reset
`define RSI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the following cycle, off while in reset
`define RSI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg
// widths, constants and shared types of the ema rsi indicator
// ----------------------------------------------------------------------------
`default_nettype none

package rsi_pkg;

    localparam int AVG_W     = 48;          // average width, fixed point
    localparam int K_FRAC    = 16;          // fraction bits of the smoothing factor
    localparam int K_W       = K_FRAC + 1;  // factor up to and including one
    localparam int CFG_W     = K_W;
    localparam int RSI_W     = 23;
    localparam int RSI_SCALE = 100;
    localparam int INT_BITS  = 7;           // bits of the integer part, 100 < 2^7

    localparam logic [AVG_W-1:0] AVG_MAX = '1;
    localparam logic [K_W-1:0]   K_ONE   = {1'b1, {K_FRAC{1'b0}}};
    localparam logic [CFG_W-1:0] K_RESET = 17'd8738;

    typedef struct packed {
        logic busy;  // quotient bits still being produced
        logic done;  // result valid, held until the next start
    } t_div_sts;

endpackage

`default_nettype wire

// File: hdl/rsi_div.sv
// ----------------------------------------------------------------------------
// rsi_div
// bit-serial restoring divider: rsi = 100 * up * 2^f / (up + down)
// ----------------------------------------------------------------------------
`default_nettype none
`include "rsi_ema_indicator_defines.svh"

module rsi_div
    import rsi_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [AVG_W-1:0]    i_up,
    input  logic [AVG_W-1:0]    i_down,
    output t_div_sts            o_sts,
    output logic [RSI_W-1:0]    o_rsi_value
);

    localparam int QUO_W = FRACTION_BITS + INT_BITS;
    localparam int CNT_W = $clog2(QUO_W);
    localparam int SUM_W = AVG_W + 1;
    localparam int DEN_W = SUM_W + INT_BITS;
    localparam int NUM_W = AVG_W + INT_BITS;
    localparam logic [RSI_W-1:0] RSI_FULL = RSI_W'(RSI_SCALE << FRACTION_BITS);

    logic [SUM_W-1:0] sum;
    logic [NUM_W-1:0] num;
    logic [DEN_W:0]   trial;
    logic             sum_zero;

    logic             r_busy;
    logic             r_done;
    logic             r_zero;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [QUO_W-1:0] r_quo;

    assign sum      = {1'b0, i_up} + {1'b0, i_down};
    assign sum_zero = (sum == '0);
    // 100 = 64 + 32 + 4
    assign num      = NUM_W'({i_up, 6'b0}) + NUM_W'({i_up, 5'b0}) + NUM_W'({i_up, 2'b0});
    assign trial    = {r_rem, 1'b0} - {1'b0, r_den};

    // divisor is sum << 7 so the quotient comes out as 7 + f bits, msb first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_zero <= 1'b0;
        end else if (i_start) begin
            r_busy <= !sum_zero;
            r_done <= sum_zero;
            r_zero <= sum_zero;
        end else if (r_busy && (r_cnt == '0)) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
        if (i_start) begin
            r_cnt <= CNT_W'(QUO_W - 1);
            r_den <= {sum, {INT_BITS{1'b0}}};
            r_rem <= DEN_W'(num);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_rem <= trial[DEN_W] ? {r_rem[DEN_W-2:0], 1'b0} : trial[DEN_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], !trial[DEN_W]};
        end
    end

    assign o_sts       = '{busy: r_busy, done: r_done};
    assign o_rsi_value = r_zero ? RSI_FULL : RSI_W'(r_quo);

    `RSI_ASSERT_NOW(a_busy_not_done, i_clk, i_rst_n, r_busy, !r_done, "divider busy and done")
    `RSI_ASSERT_NOW(a_rem_below_den, i_clk, i_rst_n, r_busy, (r_rem < r_den), "remainder not below divisor")
    `RSI_ASSERT_NOW(a_done_source, i_clk, i_rst_n, $rose(r_done), ($past(r_busy) || $past(i_start)), "done without work")

endmodule

`default_nettype wire

// File: hdl/rsi_ema_indicator.sv
// ----------------------------------------------------------------------------
// rsi_ema_indicator
// relative strength index over exponential averages of up and down moves
// ----------------------------------------------------------------------------
// channel   direction  handshake                      payload
// cfg       in         i_cfg_valid / o_cfg_ready      i_cfg_smoothing_factor
// price     in         i_in_valid  / o_in_ready       i_close_price, i_series_start
// rsi       out        o_out_valid / i_out_ready      o_rsi_value
//
// a running item passes from accept to result through 17 shift-add steps
// over the factor bits, the average update, the divider start and
// FRACTION_BITS + 7 divider steps. the second price of a series skips the
// multiply; the first price of a series only starts it and gives no result.
// with both averages zero the divider steps are skipped.
// reset is synchronous, clears the averages, the previous price and the series
// phase, and returns the factor to its reset value.
// a new price word is taken while a result still waits in the output register;
// the next result then waits until the earlier result is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rsi_ema_indicator_defines.svh"

module rsi_ema_indicator
    import rsi_pkg::*;
#(
    parameter int PRICE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_W-1:0]        i_cfg_smoothing_factor,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [PRICE_WIDTH-1:0]  i_close_price,
    input  logic                    i_series_start,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [RSI_W-1:0]        o_rsi_value
);

    localparam int FIX_W = PRICE_WIDTH + FRACTION_BITS;
    localparam int EXT_W = (FIX_W > AVG_W) ? FIX_W : AVG_W + 1;
    localparam int MC_W  = $clog2(K_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_UPDATE,
        S_DIV_GO,
        S_DIV_WAIT
    } t_state;

    typedef enum logic [1:0] {
        PH_NONE,
        PH_ONE,
        PH_RUN
    } t_phase;

    function automatic logic [AVG_W-1:0] sat_avg(input logic [AVG_W+1:0] v);
        return (|v[AVG_W+1:AVG_W]) ? AVG_MAX : v[AVG_W-1:0];
    endfunction

    t_state                 r_state,     n_state;
    t_phase                 r_phase,     n_phase;
    logic [PRICE_WIDTH-1:0] r_prev,      n_prev;
    logic [AVG_W-1:0]       r_up,        n_up;
    logic [AVG_W-1:0]       r_down,      n_down;
    logic                   r_out_valid, n_out_valid;
    logic [RSI_W-1:0]       r_rsi,       n_rsi;
    logic [CFG_W-1:0]       r_smooth,    n_smooth;
    logic [AVG_W-1:0]       r_mag,       n_mag;
    logic                   r_rising,    n_rising;
    logic [K_W-1:0]         r_kd,        n_kd;
    logic [K_W-1:0]         r_kc,        n_kc;
    logic [AVG_W:0]         r_acc_d,     n_acc_d;
    logic [AVG_W:0]         r_acc_u,     n_acc_u;
    logic [AVG_W:0]         r_acc_n,     n_acc_n;
    logic [MC_W-1:0]        r_mcnt,      n_mcnt;

    logic                   in_acc;
    logic                   rising;
    logic [PRICE_WIDTH-1:0] diff_up;
    logic [PRICE_WIDTH-1:0] diff_dn;
    logic [PRICE_WIDTH-1:0] delta;
    logic [EXT_W-1:0]       fix_ext;
    logic [AVG_W-1:0]       mag;
    logic [K_W-1:0]         k_clamp;
    logic [AVG_W:0]         sum_d;
    logic [AVG_W:0]         sum_u;
    logic [AVG_W:0]         sum_n;
    logic                   div_start;
    t_div_sts               div_sts;
    logic [RSI_W-1:0]       div_rsi;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_rsi_value = r_rsi;
    assign in_acc      = i_in_valid && o_in_ready;

    assign rising  = (i_close_price > r_prev);
    assign diff_up = i_close_price - r_prev;
    assign diff_dn = r_prev - i_close_price;
    assign delta   = rising ? diff_up : diff_dn;
    // delta scaled to fixed point, clipped at the top of the average range
    assign fix_ext = EXT_W'({delta, {FRACTION_BITS{1'b0}}});
    assign mag     = (|fix_ext[EXT_W-1:AVG_W]) ? AVG_MAX : fix_ext[AVG_W-1:0];
    assign k_clamp = (r_smooth > K_ONE) ? K_ONE : r_smooth;

    // lsb-first shift-add: each step adds the operand when the factor bit is set
    assign sum_d = r_acc_d + (r_kd[0] ? {1'b0, r_mag}  : '0);
    assign sum_u = r_acc_u + (r_kc[0] ? {1'b0, r_up}   : '0);
    assign sum_n = r_acc_n + (r_kc[0] ? {1'b0, r_down} : '0);

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_prev      = r_prev;
        n_up        = r_up;
        n_down      = r_down;
        n_out_valid = r_out_valid;
        n_rsi       = r_rsi;
        n_smooth    = r_smooth;
        n_mag       = r_mag;
        n_rising    = r_rising;
        n_kd        = r_kd;
        n_kc        = r_kc;
        n_acc_d     = r_acc_d;
        n_acc_u     = r_acc_u;
        n_acc_n     = r_acc_n;
        n_mcnt      = r_mcnt;
        div_start   = 1'b0;

        if (i_cfg_valid) begin
            n_smooth = i_cfg_smoothing_factor;
        end
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_prev = i_close_price;
                    if (i_series_start || (r_phase == PH_NONE)) begin
                        n_up    = '0;
                        n_down  = '0;
                        n_phase = PH_ONE;
                    end else if (r_phase == PH_ONE) begin
                        // first delta seeds its own average
                        if (rising) begin
                            n_up = mag;
                        end else begin
                            n_down = mag;
                        end
                        n_phase = PH_RUN;
                        n_state = S_DIV_GO;
                    end else begin
                        n_mag    = mag;
                        n_rising = rising;
                        n_kd     = k_clamp;
                        n_kc     = K_ONE - k_clamp;
                        n_acc_d  = '0;
                        n_acc_u  = '0;
                        n_acc_n  = '0;
                        n_mcnt   = '0;
                        n_state  = S_MUL;
                    end
                end
            end
            S_MUL: begin
                if (r_mcnt == MC_W'(K_FRAC)) begin
                    // the weight-one bit adds without a shift
                    n_acc_d = sum_d;
                    n_acc_u = sum_u;
                    n_acc_n = sum_n;
                    n_state = S_UPDATE;
                end else begin
                    n_acc_d = {1'b0, sum_d[AVG_W:1]};
                    n_acc_u = {1'b0, sum_u[AVG_W:1]};
                    n_acc_n = {1'b0, sum_n[AVG_W:1]};
                    n_kd    = {1'b0, r_kd[K_W-1:1]};
                    n_kc    = {1'b0, r_kc[K_W-1:1]};
                    n_mcnt  = r_mcnt + 1'b1;
                end
            end
            S_UPDATE: begin
                if (r_rising) begin
                    n_up   = sat_avg({1'b0, r_acc_d} + {1'b0, r_acc_u});
                    n_down = r_acc_n[AVG_W-1:0];
                end else begin
                    n_up   = r_acc_u[AVG_W-1:0];
                    n_down = sat_avg({1'b0, r_acc_d} + {1'b0, r_acc_n});
                end
                n_state = S_DIV_GO;
            end
            S_DIV_GO: begin
                div_start = 1'b1;
                n_state   = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_sts.done && (!r_out_valid || i_out_ready)) begin
                    n_out_valid = 1'b1;
                    n_rsi       = div_rsi;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_NONE;
            r_prev      <= '0;
            r_up        <= '0;
            r_down      <= '0;
            r_out_valid <= 1'b0;
            r_smooth    <= K_RESET;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_prev      <= n_prev;
            r_up        <= n_up;
            r_down      <= n_down;
            r_out_valid <= n_out_valid;
            r_smooth    <= n_smooth;
        end
        r_rsi    <= n_rsi;
        r_mag    <= n_mag;
        r_rising <= n_rising;
        r_kd     <= n_kd;
        r_kc     <= n_kc;
        r_acc_d  <= n_acc_d;
        r_acc_u  <= n_acc_u;
        r_acc_n  <= n_acc_n;
        r_mcnt   <= n_mcnt;
    end

    rsi_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_up        (r_up),
        .i_down      (r_down),
        .o_sts       (div_sts),
        .o_rsi_value (div_rsi)
    );

    `RSI_ASSERT_NOW(a_mul_running, i_clk, i_rst_n, (r_state == S_MUL), (r_phase == PH_RUN), "multiply outside a running series")
    `RSI_ASSERT_NOW(a_out_from_div, i_clk, i_rst_n, $rose(r_out_valid), $past(div_sts.done), "result without divider done")
    `RSI_ASSERT_NEXT(a_seed_clear, i_clk, i_rst_n, (in_acc && (i_series_start || (r_phase == PH_NONE))), ((r_up == '0) && (r_down == '0) && (r_phase == PH_ONE)), "series start did not clear averages")

endmodule

`default_nettype wire

// File: tb/sv/rsi_ema_checker.sv
// ----------------------------------------------------------------------------
// rsi_ema_checker
// watches the factor, price and rsi channels, predicts every rsi word from the
// accepted price words and compares it with the word the block delivers
// ----------------------------------------------------------------------------
module rsi_ema_checker
    import rsi_pkg::*;
#(
    parameter int PRICE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [CFG_W-1:0]        i_cfg_smoothing_factor,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic [PRICE_WIDTH-1:0]  i_close_price,
    input  logic                    i_series_start,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic [RSI_W-1:0]        i_rsi_value,
    output int unsigned             o_fail_count,
    output int unsigned             o_pending,
    output int unsigned             o_rsi_seen
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SHOW_LIMIT = 10;

    typedef enum logic [1:0] {
        PH_NONE,  // no price seen
        PH_ONE,   // first price of the series stored
        PH_RUN    // averages running
    } t_series_phase;

    typedef struct {
        logic [RSI_W-1:0] rsi;
        int unsigned      word_no;
    } t_rsi_due;

    logic [CFG_W-1:0]       factor;
    logic [PRICE_WIDTH-1:0] last_close;
    logic [AVG_W-1:0]       up_avg;
    logic [AVG_W-1:0]       down_avg;
    t_series_phase          phase;

    t_rsi_due    rsi_due_q[$];
    int unsigned fail_cnt;
    int unsigned price_words;
    int unsigned rsi_words;

    // floor(a * w / 2^16), product below 2^64
    function automatic logic [AVG_W-1:0] scale_k(input logic [AVG_W-1:0] a,
                                                 input logic [K_W-1:0] w);
        logic [AVG_W+K_W-1:0] prod;
        prod = a * w;
        return prod[K_FRAC +: AVG_W];
    endfunction

    function automatic logic [AVG_W-1:0] to_fixed(input logic [PRICE_WIDTH-1:0] delta);
        logic [127:0] wide;
        wide = 128'(delta) << FRACTION_BITS;
        if (wide > 128'(AVG_MAX))
            return AVG_MAX;
        return wide[AVG_W-1:0];
    endfunction

    function automatic logic [AVG_W-1:0] ema_step(input logic [AVG_W-1:0] avg,
                                                  input logic [AVG_W-1:0] mag,
                                                  input logic [K_W-1:0] k);
        logic [AVG_W:0] sum;
        sum = {1'b0, scale_k(mag, k)} + {1'b0, scale_k(avg, K_ONE - k)};
        if (sum > {1'b0, AVG_MAX})
            return AVG_MAX;
        return sum[AVG_W-1:0];
    endfunction

    // exact restoring division, integer part first then the fraction bits
    function automatic logic [RSI_W-1:0] rsi_calc(input logic [AVG_W-1:0] up,
                                                  input logic [AVG_W-1:0] down);
        bit [63:0] sum;
        bit [63:0] num;
        bit [63:0] quo;
        bit [63:0] rem;
        sum = 64'(up) + 64'(down);
        if (sum == 0)
            return RSI_W'(64'(RSI_SCALE) << FRACTION_BITS);
        num = 64'(RSI_SCALE) * 64'(up);
        quo = num / sum;
        rem = num % sum;
        for (int b = 0; b < FRACTION_BITS; b++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= sum) begin
                rem = rem - sum;
                quo[0] = 1'b1;
            end
        end
        return quo[RSI_W-1:0];
    endfunction

    task automatic predict_rsi(input logic [PRICE_WIDTH-1:0] price, input logic start,
                               output bit gives, output logic [RSI_W-1:0] rsi);
        logic [K_W-1:0]         k;
        logic                   rising;
        logic [PRICE_WIDTH-1:0] delta;
        logic [AVG_W-1:0]       mag;
        k = (factor > K_ONE) ? K_ONE : factor;
        gives = 1'b0;
        rsi = '0;
        if (start || phase == PH_NONE) begin
            last_close = price;
            up_avg = '0;
            down_avg = '0;
            phase = PH_ONE;
        end else begin
            rising = price > last_close;
            delta = rising ? price - last_close : last_close - price;
            mag = to_fixed(delta);
            last_close = price;
            if (phase == PH_ONE) begin
                // first move of the series seeds its own average
                if (rising)
                    up_avg = mag;
                else
                    down_avg = mag;
                phase = PH_RUN;
            end else if (rising) begin
                up_avg = ema_step(up_avg, mag, k);
                down_avg = scale_k(down_avg, K_ONE - k);
            end else begin
                up_avg = scale_k(up_avg, K_ONE - k);
                down_avg = ema_step(down_avg, mag, k);
            end
            gives = 1'b1;
            rsi = rsi_calc(up_avg, down_avg);
        end
    endtask

    always @(posedge i_clk) begin
        bit               gives;
        logic [RSI_W-1:0] rsi;
        t_rsi_due         due;
        if (!i_rst_n) begin
            factor = K_RESET;
            last_close = '0;
            up_avg = '0;
            down_avg = '0;
            phase = PH_NONE;
            rsi_due_q.delete();
            fail_cnt = 0;
            price_words = 0;
            rsi_words = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                factor = i_cfg_smoothing_factor;

            // compare first: a word accepted now cannot be answered in the same cycle
            if (i_out_valid && i_out_ready) begin
                rsi_words++;
                if (rsi_due_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= SHOW_LIMIT)
                        $display("%0t: rsi word %0d arrived with nothing expected",
                                 $realtime, i_rsi_value);
                end else begin
                    due = rsi_due_q.pop_front();
                    if (i_rsi_value !== due.rsi) begin
                        fail_cnt++;
                        if (fail_cnt <= SHOW_LIMIT)
                            $display("%0t: rsi mismatch for price word %0d: expected %0d got %0d",
                                     $realtime, due.word_no, due.rsi, i_rsi_value);
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                predict_rsi(i_close_price, i_series_start, gives, rsi);
                if (gives) begin
                    due.rsi = rsi;
                    due.word_no = price_words;
                    rsi_due_q.push_back(due);
                end
                price_words++;
            end
        end
        o_fail_count <= fail_cnt;
        o_pending <= rsi_due_q.size();
        o_rsi_seen <= rsi_words;
    end

endmodule

// File: tb/sv/tb_rsi_ema_indicator.sv
// ----------------------------------------------------------------------------
// tb_rsi_ema_indicator
// drives directed and random price series through the ema rsi indicator
// under several smoothing factors, with random gaps on both channels and one
// long output hold-off; the checker beside the block judges every rsi word
// ----------------------------------------------------------------------------
module tb_rsi_ema_indicator;

    import rsi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRICE_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;

    localparam int unsigned PHASE_WORDS  = 290;
    localparam int unsigned DRAIN_CYCLES = 60;    // above the item latency
    localparam int unsigned HOLD_CYCLES  = 800;
    localparam int unsigned IDLE_LIMIT   = 4000;
    localparam int          N_PHASES     = 7;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_W-1:0]       i_cfg_smoothing_factor = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic [PRICE_WIDTH-1:0] i_close_price = '0;
    logic                   i_series_start = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [RSI_W-1:0]       o_rsi_value;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned rsi_seen;
    int unsigned words_sent = 0;
    int unsigned factors_written = 0;
    int unsigned hold_ticket = 0;
    int unsigned idle_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    rsi_ema_indicator #(
        .PRICE_WIDTH   (PRICE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_smoothing_factor (i_cfg_smoothing_factor),
        .i_in_valid             (i_in_valid),
        .o_in_ready             (o_in_ready),
        .i_close_price          (i_close_price),
        .i_series_start         (i_series_start),
        .o_out_valid            (o_out_valid),
        .i_out_ready            (i_out_ready),
        .o_rsi_value            (o_rsi_value)
    );

    rsi_ema_checker #(
        .PRICE_WIDTH   (PRICE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_check (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_valid            (i_cfg_valid),
        .i_cfg_ready            (o_cfg_ready),
        .i_cfg_smoothing_factor (i_cfg_smoothing_factor),
        .i_in_valid             (i_in_valid),
        .i_in_ready             (o_in_ready),
        .i_close_price          (i_close_price),
        .i_series_start         (i_series_start),
        .i_out_valid            (o_out_valid),
        .i_out_ready            (i_out_ready),
        .i_rsi_value            (o_rsi_value),
        .o_fail_count           (fail_count),
        .o_pending              (pending),
        .o_rsi_seen             (rsi_seen)
    );

    // mostly no gap, some short ones, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    task automatic send_price(input logic [PRICE_WIDTH-1:0] price, input logic start,
                              input bit no_idle);
        int unsigned gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_close_price <= price;
        i_series_start <= start;
        do @(posedge i_clk); while (!o_in_ready);
        words_sent++;
    endtask

    // only once every rsi word is back and the block has settled
    task automatic write_factor(input logic [CFG_W-1:0] value);
        // wait for the next edge so the checker count includes the last price word
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_smoothing_factor <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        factors_written++;
    endtask

    task automatic random_series(input int unsigned n_words, input bit no_idle);
        int unsigned            sent;
        int unsigned            len;
        int unsigned            style;
        logic [PRICE_WIDTH-1:0] price;
        logic                   start;
        sent = 0;
        while (sent < n_words) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 80) : $urandom_range(2, 24);
            style = $urandom_range(0, 9);
            price = $urandom;
            for (int unsigned j = 0; j < len && sent < n_words; j++) begin
                if (j == 0)
                    start = ($urandom_range(0, 19) != 0);  // sometimes a series runs on
                else
                    start = ($urandom_range(0, 59) == 0);  // early restart
                if (j != 0) begin
                    if (style < 6) begin
                        if ($urandom_range(0, 4) != 0)
                            price = price + $urandom_range(0, 200) - 32'd100;
                    end else if (style < 8) begin
                        if ($urandom_range(0, 2) == 0)
                            price = price + $urandom_range(0, 6) - 32'd3;
                    end else if (style == 8) begin
                        price = $urandom;
                    end else begin
                        case ($urandom_range(0, 2))
                            0: price = '0;
                            1: price = '1;
                            default: price = $urandom;
                        endcase
                    end
                end
                send_price(price, start, no_idle);
                sent++;
            end
        end
    endtask

    // receiver: random gaps, runs without gaps, and the long hold-off on request
    initial begin
        int unsigned hold_left;
        int unsigned free_left;
        int unsigned holds_seen;
        int unsigned gap;
        hold_left = 0;
        free_left = 0;
        holds_seen = 0;
        forever begin
            @(posedge i_clk);
            if (hold_ticket != holds_seen) begin
                holds_seen = hold_ticket;
                hold_left = HOLD_CYCLES;
                free_left = 0;
            end
            if (hold_left != 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else if (free_left != 0) begin
                i_out_ready <= 1'b1;
                free_left--;
            end else if ($urandom_range(0, 199) == 0) begin
                i_out_ready <= 1'b1;
                free_left = 300;
            end else begin
                gap = pick_gap();
                if (gap == 0) begin
                    i_out_ready <= 1'b1;
                end else begin
                    i_out_ready <= 1'b0;
                    hold_left = gap - 1;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_cfg_valid && o_cfg_ready) || (i_in_valid && o_in_ready)
                || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [CFG_W-1:0] factor_plan[N_PHASES];
        factor_plan[0] = K_ONE;
        factor_plan[1] = '0;
        factor_plan[2] = '1;                       // above one, acts as one
        factor_plan[3] = CFG_W'(1);
        factor_plan[4] = CFG_W'($urandom_range(0, 131071));
        factor_plan[5] = CFG_W'(32768);
        factor_plan[6] = CFG_W'($urandom_range(2, 65535));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part under the reset factor
        send_price(32'd100, 1'b0, 1'b0);           // first price after reset, no start flag
        send_price(32'd110, 1'b0, 1'b0);           // seeds the up average
        send_price(32'd110, 1'b0, 1'b0);           // zero delta counts as a down move
        send_price(32'd90, 1'b0, 1'b0);
        send_price(32'hffff_ffff, 1'b0, 1'b0);     // near-widest up move
        send_price(32'd0, 1'b0, 1'b0);             // widest down move
        send_price(32'd0, 1'b1, 1'b0);             // restart
        send_price(32'd0, 1'b0, 1'b0);             // both averages zero
        send_price(32'd0, 1'b0, 1'b0);
        send_price(32'hffff_ffff, 1'b1, 1'b0);
        send_price(32'd0, 1'b0, 1'b0);             // seeds the down average at its widest
        send_price(32'hffff_ffff, 1'b0, 1'b0);
        send_price(32'd5, 1'b1, 1'b0);             // back-to-back restarts
        send_price(32'd5, 1'b1, 1'b0);
        send_price(32'd7, 1'b0, 1'b0);
        send_price(32'h8000_0000, 1'b0, 1'b0);
        send_price(32'h7fff_ffff, 1'b0, 1'b0);
        send_price(32'h5555_5555, 1'b0, 1'b0);
        send_price(32'haaaa_aaaa, 1'b0, 1'b0);
        i_in_valid <= 1'b0;

        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_factor(factor_plan[ph]);
            if (ph == 5)
                hold_ticket <= hold_ticket + 1;    // block fills while the output is held
            random_series(PHASE_WORDS, ph == 1);
            i_in_valid <= 1'b0;
        end

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run: %0d price words sent, %0d rsi words checked, %0d factor writes",
                 words_sent, rsi_seen, factors_written);
        $display("run: factors included zero, one, above one and the reset value, one long hold-off");
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
